// File: design/oplex_pkg.sv
package oplex_pkg;

  // Source characters
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;
  localparam logic [7:0] CH_LESS    = 8'h3c;
  localparam logic [7:0] CH_GREATER = 8'h3e;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_LF      = 8'h0a;

  // Held operator codes
  localparam logic [2:0] PEND_NONE    = 3'd0;
  localparam logic [2:0] PEND_BANG    = 3'd1;
  localparam logic [2:0] PEND_EQUAL   = 3'd2;
  localparam logic [2:0] PEND_LESS    = 3'd3;
  localparam logic [2:0] PEND_GREATER = 3'd4;
  localparam logic [2:0] PEND_SLASH   = 3'd5;

  // Token kinds
  localparam logic [4:0] TOK_LPAREN    = 5'd0;
  localparam logic [4:0] TOK_RPAREN    = 5'd1;
  localparam logic [4:0] TOK_LBRACE    = 5'd2;
  localparam logic [4:0] TOK_RBRACE    = 5'd3;
  localparam logic [4:0] TOK_COMMA     = 5'd4;
  localparam logic [4:0] TOK_DOT       = 5'd5;
  localparam logic [4:0] TOK_MINUS     = 5'd6;
  localparam logic [4:0] TOK_PLUS      = 5'd7;
  localparam logic [4:0] TOK_SEMICOLON = 5'd8;
  localparam logic [4:0] TOK_STAR      = 5'd9;
  localparam logic [4:0] TOK_SINGLE_BASE = 5'd8;
  localparam logic [4:0] TOK_SLASH     = 5'd18;

  // One result, without the position fields
  typedef struct packed {
    logic       err;
    logic [4:0] kind;
    logic       len2;    // two-byte lexeme
    logic       at_off;  // lexeme starts at the current byte, else at the held byte
  } tok_t;

  // Scanner decision for one source byte
  typedef struct packed {
    logic [1:0] count;
    tok_t       r0;
    tok_t       r1;
    logic [2:0] pend;
    logic       comment;
    logic       load_start;
    logic       line_inc;
  } scan_t;

endpackage

// File: design/oplex_scan.sv
module oplex_scan (
  input  logic [7:0]       byte_i,
  input  logic             eos_i,
  input  logic [2:0]       pend_i,
  input  logic             comment_i,
  output oplex_pkg::scan_t scan_o
);

  logic            f_emit;
  logic            f_err;
  logic [4:0]      f_kind;
  logic            f_set;
  logic [2:0]      f_pend;
  logic            f_nl;

  // Decode a byte as if nothing were held
  always_comb begin
    f_emit = 1'b1;
    f_err  = 1'b0;
    f_kind = oplex_pkg::TOK_LPAREN;
    f_set  = 1'b0;
    f_pend = oplex_pkg::PEND_NONE;
    f_nl   = 1'b0;
    unique case (byte_i) inside
      oplex_pkg::CH_LPAREN:  f_kind = oplex_pkg::TOK_LPAREN;
      oplex_pkg::CH_RPAREN:  f_kind = oplex_pkg::TOK_RPAREN;
      oplex_pkg::CH_LBRACE:  f_kind = oplex_pkg::TOK_LBRACE;
      oplex_pkg::CH_RBRACE:  f_kind = oplex_pkg::TOK_RBRACE;
      oplex_pkg::CH_COMMA:   f_kind = oplex_pkg::TOK_COMMA;
      oplex_pkg::CH_DOT:     f_kind = oplex_pkg::TOK_DOT;
      oplex_pkg::CH_MINUS:   f_kind = oplex_pkg::TOK_MINUS;
      oplex_pkg::CH_PLUS:    f_kind = oplex_pkg::TOK_PLUS;
      oplex_pkg::CH_SEMI:    f_kind = oplex_pkg::TOK_SEMICOLON;
      oplex_pkg::CH_STAR:    f_kind = oplex_pkg::TOK_STAR;
      oplex_pkg::CH_BANG: begin
        f_emit = 1'b0; f_set = 1'b1; f_pend = oplex_pkg::PEND_BANG;
      end
      oplex_pkg::CH_EQUAL: begin
        f_emit = 1'b0; f_set = 1'b1; f_pend = oplex_pkg::PEND_EQUAL;
      end
      oplex_pkg::CH_LESS: begin
        f_emit = 1'b0; f_set = 1'b1; f_pend = oplex_pkg::PEND_LESS;
      end
      oplex_pkg::CH_GREATER: begin
        f_emit = 1'b0; f_set = 1'b1; f_pend = oplex_pkg::PEND_GREATER;
      end
      oplex_pkg::CH_SLASH: begin
        f_emit = 1'b0; f_set = 1'b1; f_pend = oplex_pkg::PEND_SLASH;
      end
      oplex_pkg::CH_SPACE, oplex_pkg::CH_TAB, oplex_pkg::CH_CR: f_emit = 1'b0;
      oplex_pkg::CH_LF: begin
        f_emit = 1'b0; f_nl = 1'b1;
      end
      default: f_err = 1'b1;
    endcase
  end

  function automatic logic [4:0] single_kind(input logic [2:0] p);
    if (p == oplex_pkg::PEND_SLASH) begin
      return oplex_pkg::TOK_SLASH;
    end
    return oplex_pkg::TOK_SINGLE_BASE + {1'b0, p, 1'b0};
  endfunction

  always_comb begin
    oplex_pkg::tok_t res [2];
    oplex_pkg::tok_t t;
    logic [1:0]      cnt;
    logic            rescan;
    res[0] = '0;
    res[1] = '0;
    t      = '0;
    cnt    = 2'd0;
    rescan = 1'b0;
    scan_o = '0;
    scan_o.pend    = pend_i;
    scan_o.comment = comment_i;

    if (comment_i) begin
      if (byte_i == oplex_pkg::CH_LF) begin
        scan_o.comment  = 1'b0;
        scan_o.line_inc = 1'b1;
      end
    end else if (pend_i == oplex_pkg::PEND_SLASH) begin
      scan_o.pend = oplex_pkg::PEND_NONE;
      if (byte_i == oplex_pkg::CH_SLASH) begin
        scan_o.comment = 1'b1;
      end else begin
        res[0] = '{err: 1'b0, kind: oplex_pkg::TOK_SLASH, len2: 1'b0, at_off: 1'b0};
        cnt    = 2'd1;
        rescan = 1'b1;
      end
    end else if (pend_i != oplex_pkg::PEND_NONE) begin
      scan_o.pend = oplex_pkg::PEND_NONE;
      if (byte_i == oplex_pkg::CH_EQUAL) begin
        res[0] = '{err: 1'b0, kind: single_kind(pend_i) + 5'd1, len2: 1'b1, at_off: 1'b0};
      end else begin
        res[0] = '{err: 1'b0, kind: single_kind(pend_i), len2: 1'b0, at_off: 1'b0};
        rescan = 1'b1;
      end
      cnt = 2'd1;
    end else begin
      rescan = 1'b1;
    end

    if (rescan) begin
      if (f_emit) begin
        t = '{err: f_err, kind: f_err ? oplex_pkg::TOK_LPAREN : f_kind, len2: 1'b0,
              at_off: 1'b1};
        res[cnt[0]] = t;
        cnt = cnt + 2'd1;
      end
      if (f_set) begin
        scan_o.pend       = f_pend;
        scan_o.load_start = 1'b1;
      end
      scan_o.line_inc = f_nl;
    end

    // Flush an operator that was picked up by this last byte
    if (eos_i) begin
      if (scan_o.pend != oplex_pkg::PEND_NONE && cnt != 2'd2) begin
        res[cnt[0]] = '{err: 1'b0, kind: single_kind(scan_o.pend), len2: 1'b0,
                        at_off: 1'b1};
        cnt = cnt + 2'd1;
      end
      scan_o.pend    = oplex_pkg::PEND_NONE;
      scan_o.comment = 1'b0;
    end

    scan_o.count = cnt;
    scan_o.r0    = res[0];
    scan_o.r1    = res[1];
  end

endmodule

// File: design/oplex_obuf.sv
module oplex_obuf #(
  parameter int Width = 50
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  logic [Width-1:0] push0_i,
  input  logic [Width-1:0] push1_i,
  output logic             room_o,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  input  logic             ready_i
);

  localparam int Slots = 3;

  logic [1:0]       cnt_q, cnt_d;
  logic [Width-1:0] slot_q [Slots];
  logic [Width-1:0] slot_d [Slots];
  logic             pop;
  logic [1:0]       base;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = slot_q[0];
  // Room for a whole two-result transaction, whatever the output does
  assign room_o  = cnt_q <= 2'd1;
  assign base    = cnt_q - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      if (pop && i < Slots - 1) begin
        slot_d[i] = slot_q[i+1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if (push_cnt_i != 2'd0 && base == 2'(i)) begin
        slot_d[i] = push0_i;
      end
      if (push_cnt_i == 2'd2 && base + 2'd1 == 2'(i)) begin
        slot_d[i] = push1_i;
      end
    end
    cnt_d = base + push_cnt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Slots; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  // A full buffer takes no push and drains at most one entry a cycle
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd3 |=> cnt_q >= 2'd2)
    else $error("full result buffer changed by more than one entry");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i != 2'd0 |-> cnt_q <= 2'd1)
    else $error("results pushed without room");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) - {1'b0, $past(pop)} + $past(push_cnt_i))
    else $error("result count lost track");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_cnt_i == 2'd0 && cnt_q == 2'd1) |=> !valid_o)
    else $error("drained buffer still shows a result");

endmodule

// File: design/operator_punctuation_lexer_core.sv
// Each result is registered in the result buffer; the master side shows the oldest one.
// Throughput: one byte per cycle while the buffer has room; a byte that yields two results
// holds s_axis_tready_o low until the three-entry result buffer drains to one result.
// The s_axis_tready_o depends only on the buffer fill, not on m_axis_tready_i.
// Reset: rst_ni clears the buffer and the scanner state; line count returns to 1.
module operator_punctuation_lexer_core #(
  parameter  int LINE_BITS   = 16,
  parameter  int OFFSET_BITS = 24,
  localparam int PayW  = 5 + LINE_BITS + OFFSET_BITS + 2,
  localparam int DataW = (PayW + 7) / 8 * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // source_byte
  input  logic             s_axis_tlast_i,   // end_of_source
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // token_kind, line_number, lexeme_start, lexeme_length, zero fill
  output logic [DataW-1:0] m_axis_tdata_o,
  output logic             m_axis_tuser_o,   // result_kind
  output logic             m_axis_tlast_o    // last_of_run
);

  localparam int EntW = PayW + 2;

  logic [2:0]             pend_q;
  logic                   comment_q;
  logic [LINE_BITS-1:0]   line_q;
  logic [OFFSET_BITS-1:0] off_q;
  logic [OFFSET_BITS-1:0] pstart_q;
  logic                   accept;
  oplex_pkg::scan_t       scan;
  logic [EntW-1:0]        ent0, ent1, ent_out;
  logic [1:0]             push_cnt;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  oplex_scan u_scan (
    .byte_i    (s_axis_tdata_i),
    .eos_i     (s_axis_tlast_i),
    .pend_i    (pend_q),
    .comment_i (comment_q),
    .scan_o    (scan)
  );

  function automatic logic [EntW-1:0] pack(
    input oplex_pkg::tok_t        t,
    input logic                   last,
    input logic [LINE_BITS-1:0]   line,
    input logic [OFFSET_BITS-1:0] off,
    input logic [OFFSET_BITS-1:0] pstart
  );
    logic [OFFSET_BITS-1:0] start;
    start = t.at_off ? off : pstart;
    return {last, t.err, (t.len2 ? 2'd2 : 2'd1), start, line, t.kind};
  endfunction

  assign ent0 = pack(scan.r0, scan.count == 2'd1, line_q, off_q, pstart_q);
  assign ent1 = pack(scan.r1, 1'b1, line_q, off_q, pstart_q);
  assign push_cnt = accept ? scan.count : 2'd0;

  oplex_obuf #(
    .Width (EntW)
  ) u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (ent0),
    .push1_i    (ent1),
    .room_o     (s_axis_tready_o),
    .valid_o    (m_axis_tvalid_o),
    .data_o     (ent_out),
    .ready_i    (m_axis_tready_i)
  );

  assign m_axis_tdata_o = DataW'(ent_out[PayW-1:0]);
  assign m_axis_tuser_o = ent_out[PayW];
  assign m_axis_tlast_o = ent_out[PayW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= oplex_pkg::PEND_NONE;
      comment_q <= 1'b0;
      line_q    <= LINE_BITS'(1);
      off_q     <= '0;
      pstart_q  <= '0;
    end else if (accept) begin
      pend_q    <= scan.pend;
      comment_q <= scan.comment;
      if (s_axis_tlast_i) begin
        // next byte begins a new source
        line_q   <= LINE_BITS'(1);
        off_q    <= '0;
        pstart_q <= '0;
      end else begin
        if (scan.line_inc && line_q != '1) begin
          line_q <= line_q + LINE_BITS'(1);
        end
        off_q <= off_q + OFFSET_BITS'(1);
        if (scan.load_start) begin
          pstart_q <= off_q;
        end
      end
    end
  end

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line count reached zero");

  a_eos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast_i |=> pend_q == oplex_pkg::PEND_NONE && !comment_q
      && off_q == '0)
    else $error("scanner state left after end of source");

  a_comment_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comment_q |-> pend_q == oplex_pkg::PEND_NONE)
    else $error("operator held inside a comment");

endmodule

// File: sim/tb_top.sv
module tb_top;

  localparam int DATA_W = 48;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 480;
  localparam int HOLD_CYCLES = 300;
  localparam int LINE_TOP = 65535;

  localparam logic RES_TOKEN = 1'b0;
  localparam logic RES_ERROR = 1'b1;
  localparam logic [4:0] ERR_KIND = 5'd0;
  localparam logic [4:0] TOK_BANG_EQUAL = 5'd11;

  typedef struct packed {
    logic        err;
    logic [4:0]  kind;
    logic [15:0] line;
    logic [23:0] start;
    logic [1:0]  len;
    logic        last;
  } lex_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
    logic       pinned;
    lex_res_t   want;
  } row_t;

  localparam lex_res_t NO_TOK = '0;

  localparam logic [7:0] PUNCT_CHARS [15] = '{
    oplex_pkg::CH_LPAREN, oplex_pkg::CH_RPAREN, oplex_pkg::CH_LBRACE, oplex_pkg::CH_RBRACE,
    oplex_pkg::CH_COMMA, oplex_pkg::CH_DOT, oplex_pkg::CH_MINUS, oplex_pkg::CH_PLUS,
    oplex_pkg::CH_SEMI, oplex_pkg::CH_STAR, oplex_pkg::CH_BANG, oplex_pkg::CH_EQUAL,
    oplex_pkg::CH_LESS, oplex_pkg::CH_GREATER, oplex_pkg::CH_SLASH
  };
  localparam logic [7:0] BLANK_CHARS [4] = '{
    oplex_pkg::CH_SPACE, oplex_pkg::CH_TAB, oplex_pkg::CH_CR, oplex_pkg::CH_LF
  };

  // Walked from reset; offsets match row indexes up to the first end of source.
  localparam row_t OPENING_ROWS [25] = '{
    '{oplex_pkg::CH_LPAREN,  1'b0, 1'b1,
      '{RES_TOKEN, oplex_pkg::TOK_LPAREN, 16'd1, 24'd0, 2'd1, 1'b1}},
    '{oplex_pkg::CH_RPAREN,  1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_LBRACE,  1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_RBRACE,  1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_COMMA,   1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_DOT,     1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_MINUS,   1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_PLUS,    1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_SEMI,    1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_STAR,    1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_BANG,    1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_EQUAL,   1'b0, 1'b1,
      '{RES_TOKEN, TOK_BANG_EQUAL, 16'd1, 24'd10, 2'd2, 1'b1}},
    '{oplex_pkg::CH_LESS,    1'b0, 1'b0, NO_TOK},
    '{8'h61,                 1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_LF,      1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_SLASH,   1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_SLASH,   1'b0, 1'b0, NO_TOK},
    '{8'hff,                 1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_LF,      1'b0, 1'b0, NO_TOK},
    '{8'h00,                 1'b0, 1'b1,
      '{RES_ERROR, ERR_KIND, 16'd3, 24'd19, 2'd1, 1'b1}},
    '{oplex_pkg::CH_GREATER, 1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_SPACE,   1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_EQUAL,   1'b0, 1'b0, NO_TOK},
    '{oplex_pkg::CH_SLASH,   1'b1, 1'b0, NO_TOK},
    '{8'hff,                 1'b1, 1'b1,
      '{RES_ERROR, ERR_KIND, 16'd1, 24'd0, 2'd1, 1'b1}}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [7:0]        s_axis_tdata_i;
  logic              s_axis_tlast_i;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [DATA_W-1:0] m_axis_tdata_o;
  logic              m_axis_tuser_o;
  logic              m_axis_tlast_o;

  // scanner state mirror
  logic [2:0]  held_op;
  logic [23:0] held_start;
  logic        in_cmt;
  logic [15:0] line_cnt;
  logic [23:0] next_off;

  lex_res_t step_tokens[$];
  lex_res_t tokens_due[$];
  lex_res_t got_tok;
  lex_res_t want_tok;

  int   mismatches = 0;
  int   idle_run = 0;
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic hold_req;

  operator_punctuation_lexer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  function void queue_result(input logic err, input logic [4:0] kind,
                             input logic [23:0] start, input logic [1:0] len);
    step_tokens.push_back('{err, kind, line_cnt, start, len, 1'b0});
  endfunction

  function void bump_line();
    if (line_cnt != 16'(LINE_TOP)) begin
      line_cnt = line_cnt + 16'd1;
    end
  endfunction

  function logic [4:0] alone_kind(input logic [2:0] op);
    if (op == oplex_pkg::PEND_SLASH) return oplex_pkg::TOK_SLASH;
    return oplex_pkg::TOK_SINGLE_BASE + 5'(2 * op);
  endfunction

  function void scan_fresh(input logic [7:0] b, input logic [23:0] off);
    case (b)
      oplex_pkg::CH_LPAREN:  queue_result(RES_TOKEN, oplex_pkg::TOK_LPAREN, off, 2'd1);
      oplex_pkg::CH_RPAREN:  queue_result(RES_TOKEN, oplex_pkg::TOK_RPAREN, off, 2'd1);
      oplex_pkg::CH_LBRACE:  queue_result(RES_TOKEN, oplex_pkg::TOK_LBRACE, off, 2'd1);
      oplex_pkg::CH_RBRACE:  queue_result(RES_TOKEN, oplex_pkg::TOK_RBRACE, off, 2'd1);
      oplex_pkg::CH_COMMA:   queue_result(RES_TOKEN, oplex_pkg::TOK_COMMA, off, 2'd1);
      oplex_pkg::CH_DOT:     queue_result(RES_TOKEN, oplex_pkg::TOK_DOT, off, 2'd1);
      oplex_pkg::CH_MINUS:   queue_result(RES_TOKEN, oplex_pkg::TOK_MINUS, off, 2'd1);
      oplex_pkg::CH_PLUS:    queue_result(RES_TOKEN, oplex_pkg::TOK_PLUS, off, 2'd1);
      oplex_pkg::CH_SEMI:    queue_result(RES_TOKEN, oplex_pkg::TOK_SEMICOLON, off, 2'd1);
      oplex_pkg::CH_STAR:    queue_result(RES_TOKEN, oplex_pkg::TOK_STAR, off, 2'd1);
      oplex_pkg::CH_BANG:    begin held_op = oplex_pkg::PEND_BANG; held_start = off; end
      oplex_pkg::CH_EQUAL:   begin held_op = oplex_pkg::PEND_EQUAL; held_start = off; end
      oplex_pkg::CH_LESS:    begin held_op = oplex_pkg::PEND_LESS; held_start = off; end
      oplex_pkg::CH_GREATER: begin held_op = oplex_pkg::PEND_GREATER; held_start = off; end
      oplex_pkg::CH_SLASH:   begin held_op = oplex_pkg::PEND_SLASH; held_start = off; end
      oplex_pkg::CH_SPACE, oplex_pkg::CH_TAB, oplex_pkg::CH_CR: ;
      oplex_pkg::CH_LF:      bump_line();
      default:               queue_result(RES_ERROR, ERR_KIND, off, 2'd1);
    endcase
  endfunction

  // Fill step_tokens with what one source byte produces and advance the state.
  function void scan_source_byte(input logic [7:0] b, input logic eos);
    logic [23:0] off;
    logic [2:0]  op;
    off = next_off;
    step_tokens.delete();
    if (in_cmt) begin
      if (b == oplex_pkg::CH_LF) begin
        in_cmt = 1'b0;
        bump_line();
      end
    end else if (held_op == oplex_pkg::PEND_SLASH) begin
      held_op = oplex_pkg::PEND_NONE;
      if (b == oplex_pkg::CH_SLASH) begin
        in_cmt = 1'b1;
      end else begin
        queue_result(RES_TOKEN, oplex_pkg::TOK_SLASH, held_start, 2'd1);
        scan_fresh(b, off);
      end
    end else if (held_op != oplex_pkg::PEND_NONE) begin
      op = held_op;
      held_op = oplex_pkg::PEND_NONE;
      if (b == oplex_pkg::CH_EQUAL) begin
        queue_result(RES_TOKEN, alone_kind(op) + 5'd1, held_start, 2'd2);
      end else begin
        queue_result(RES_TOKEN, alone_kind(op), held_start, 2'd1);
        scan_fresh(b, off);
      end
    end else begin
      scan_fresh(b, off);
    end

    if (eos) begin
      // flush a held operator and start a new source
      if (held_op != oplex_pkg::PEND_NONE) begin
        queue_result(RES_TOKEN, alone_kind(held_op), held_start, 2'd1);
      end
      held_op = oplex_pkg::PEND_NONE;
      held_start = '0;
      in_cmt = 1'b0;
      line_cnt = 16'd1;
      next_off = '0;
    end else begin
      next_off = off + 24'd1;
    end
    if (step_tokens.size() > 0) begin
      step_tokens[step_tokens.size() - 1].last = 1'b1;
    end
  endfunction

  task send_byte(input logic [7:0] b, input logic eos, input logic pinned, input lex_res_t want);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    scan_source_byte(b, eos);
    if (pinned) begin
      tokens_due.push_back(want);
    end else begin
      foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
    end
  endtask

  function logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 60) return PUNCT_CHARS[$urandom_range(14)];
    if (r < 75) return BLANK_CHARS[$urandom_range(3)];
    if (r < 85) return oplex_pkg::CH_EQUAL;
    return 8'($urandom_range(255));
  endfunction

  task random_phase(input int tx_pct, input int rx_pct);
    int sent;
    int body;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(19) == 0) begin
        // a line comment with arbitrary contents
        send_byte(oplex_pkg::CH_SLASH, 1'b0, 1'b0, NO_TOK);
        send_byte(oplex_pkg::CH_SLASH, 1'b0, 1'b0, NO_TOK);
        body = $urandom_range(6);
        repeat (body) send_byte(8'($urandom_range(255)), 1'b0, 1'b0, NO_TOK);
        send_byte(oplex_pkg::CH_LF, ($urandom_range(9) == 0), 1'b0, NO_TOK);
        sent += body + 3;
      end else begin
        send_byte(pick_byte(), ($urandom_range(99) < 3), 1'b0, NO_TOK);
        sent++;
      end
    end
  endtask

  // receiver; a hold request stalls it once, for a HOLD_CYCLES countdown
  initial begin
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_tok = '{m_axis_tuser_o, m_axis_tdata_o[4:0], m_axis_tdata_o[20:5],
                  m_axis_tdata_o[44:21], m_axis_tdata_o[46:45], m_axis_tlast_o};
      if (tokens_due.size() == 0) begin
        report("result transaction with nothing outstanding");
      end else begin
        want_tok = tokens_due.pop_front();
        check_field("result_kind", got_tok.err, want_tok.err);
        check_field("token_kind", got_tok.kind, want_tok.kind);
        check_field("line_number", got_tok.line, want_tok.line);
        check_field("lexeme_start", got_tok.start, want_tok.start);
        check_field("lexeme_length", got_tok.len, want_tok.len);
        check_field("last_of_run", got_tok.last, want_tok.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
      if (idle_run >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tlast_i <= 1'b0;
    hold_req = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    held_op = oplex_pkg::PEND_NONE;
    held_start = '0;
    in_cmt = 1'b0;
    line_cnt = 16'd1;
    next_off = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (OPENING_ROWS[i]) begin
      send_byte(OPENING_ROWS[i].b, OPENING_ROWS[i].eos, OPENING_ROWS[i].pinned,
                OPENING_ROWS[i].want);
    end

    // long result stall while bytes keep coming
    hold_req = 1'b1;
    random_phase(9, 78);
    random_phase(78, 9);
    random_phase(0, 0);

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
design/oplex_pkg.sv
design/oplex_scan.sv
design/oplex_obuf.sv
design/operator_punctuation_lexer_core.sv
sim/tb_top.sv
